FILE: hdl/tlv_stream_walker_macros.svh
// assertion helpers for the tlv stream walker
`ifndef TLV_STREAM_WALKER_MACROS_SVH
`define TLV_STREAM_WALKER_MACROS_SVH

// condition must hold at every clock edge outside reset
`define TLVSW_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tlv_stream_walker invariant violated");

// consequent must hold whenever antecedent holds
`define TLVSW_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlv_stream_walker implication violated");

`endif

FILE: hdl/tlvsw_pkg.sv
`timescale 1ns / 1ps

package tlvsw_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int CNT_W    = 14;
   localparam int STATUS_W = 2;
   localparam int HIDX_W   = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [HIDX_W-1:0] HDR_LAST = 2'd3;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TRUNC   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_TYPE    = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic                kind;
      logic [WORD_W-1:0]   rtype;
      logic [WORD_W-1:0]   rlen;
      logic [WORD_W-1:0]   voffset;
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    records;
      logic [CNT_W-1:0]    match_total;
      logic                found;
      logic [WORD_W-1:0]   first_offset;
      logic                last;
   } result_type;

endpackage

FILE: hdl/tlv_stream_walker.sv
// tlv_stream_walker: tlv record header parser, one byte per beat
// a result beat is registered into the result queue when its byte is accepted, and offered once at the head
// throughput: one byte per cycle while req_stall is low; a byte gives up to two results, which wait
//   in a four-entry result queue; req_stall rises while fewer than two are free
// reset: synchronous active high, clears walk state and queue, registers to defaults
`timescale 1ns / 1ps

`include "tlv_stream_walker_macros.svh"

module tlv_stream_walker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [tlvsw_pkg::BYTE_W-1:0]          req_byte_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_result_kind,
   output logic [tlvsw_pkg::WORD_W-1:0]          rsp_record_type,
   output logic [tlvsw_pkg::WORD_W-1:0]          rsp_record_length,
   output logic [tlvsw_pkg::WORD_W-1:0]          rsp_value_offset,
   output logic                                  rsp_type_matches,
   output logic [tlvsw_pkg::STATUS_W-1:0]        rsp_walk_status,
   output logic [tlvsw_pkg::CNT_W-1:0]           rsp_records_seen,
   output logic [tlvsw_pkg::CNT_W-1:0]           rsp_matches_seen,
   output logic                                  rsp_match_found,
   output logic [tlvsw_pkg::WORD_W-1:0]          rsp_first_match_offset,
   output logic                                  rsp_last_result,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tlvsw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tlvsw_pkg::WORD_W-1:0]          csr_wdata
);

   // config registers
   logic [tlvsw_pkg::WORD_W-1:0] buf_len_ff;
   logic [tlvsw_pkg::WORD_W-1:0] match_type_ff;

   // walk state
   logic [tlvsw_pkg::WORD_W-1:0] pos_ff, pos_in;
   logic [tlvsw_pkg::HIDX_W-1:0] hidx_ff, hidx_in;
   logic [23:0]                  hbits_ff, hbits_in;
   logic [tlvsw_pkg::WORD_W-1:0] vleft_ff, vleft_in;
   logic [tlvsw_pkg::CNT_W-1:0]  rec_cnt_ff, rec_cnt_in;
   logic [tlvsw_pkg::CNT_W-1:0]  match_cnt_ff, match_cnt_in;
   logic [tlvsw_pkg::WORD_W-1:0] first_pos_ff, first_pos_in;
   logic                         found_ff, found_in;
   logic                         len_err_ff, len_err_in;

   // result queue
   tlvsw_pkg::result_type        queue_ff [tlvsw_pkg::QUEUE_DEPTH];
   logic [tlvsw_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tlvsw_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tlvsw_pkg::QCNT_W-1:0] count_ff, count_in;

   logic                         in_accept;
   logic                         out_pop;
   logic [tlvsw_pkg::WORD_W-1:0] pos_next;
   logic [tlvsw_pkg::WORD_W-1:0] room;
   logic [31:0]                  hbits_full;
   logic                         is_last;
   logic                         hit;
   logic                         rpt_fire;
   logic [tlvsw_pkg::STATUS_W-1:0] status;
   logic [tlvsw_pkg::QCNT_W-1:0] push_n;
   tlvsw_pkg::result_type        rpt_res;
   tlvsw_pkg::result_type        sum_res;
   tlvsw_pkg::result_type        head;

   assign in_accept = req_valid & ~req_stall;
   assign out_pop   = rsp_valid & ~rsp_stall;
   assign req_stall = (count_ff > tlvsw_pkg::QCNT_W'(tlvsw_pkg::QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign csr_ready = 1'b1;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff    <= tlvsw_pkg::WORD_W'(1);
         match_type_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tlvsw_pkg::REG_BUFFER_LENGTH: buf_len_ff    <= csr_wdata;
            tlvsw_pkg::REG_MATCH_TYPE:    match_type_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-byte walk step
   always_comb begin
      pos_next   = pos_ff + tlvsw_pkg::WORD_W'(1);
      is_last    = (pos_next == buf_len_ff);
      room       = buf_len_ff - pos_next;
      hbits_full = {hbits_ff, req_byte_value};
      hit        = (hbits_full[31:16] == match_type_ff);
      rpt_fire   = 1'b0;

      pos_in       = pos_next;
      hidx_in      = hidx_ff;
      hbits_in     = hbits_ff;
      vleft_in     = vleft_ff;
      rec_cnt_in   = rec_cnt_ff;
      match_cnt_in = match_cnt_ff;
      first_pos_in = first_pos_ff;
      found_in     = found_ff;
      len_err_in   = len_err_ff;

      if (len_err_ff) begin
      end else if (vleft_ff != '0) begin
         vleft_in = vleft_ff - tlvsw_pkg::WORD_W'(1);
      end else if (hidx_ff == tlvsw_pkg::HDR_LAST) begin
         hidx_in  = '0;
         hbits_in = '0;
         if (hbits_full[15:0] > room) begin
            len_err_in = 1'b1;
         end else begin
            rpt_fire = 1'b1;
            vleft_in = hbits_full[15:0];
            if (rec_cnt_ff != tlvsw_pkg::CNT_MAX) begin
               rec_cnt_in = rec_cnt_ff + tlvsw_pkg::CNT_W'(1);
            end
            if (hit) begin
               if (match_cnt_ff != tlvsw_pkg::CNT_MAX) begin
                  match_cnt_in = match_cnt_ff + tlvsw_pkg::CNT_W'(1);
               end
               if (!found_ff) begin
                  found_in     = 1'b1;
                  first_pos_in = pos_next;
               end
            end
         end
      end else begin
         hbits_in = hbits_full[23:0];
         hidx_in  = hidx_ff + tlvsw_pkg::HIDX_W'(1);
      end

      if (len_err_in || (vleft_in != '0)) begin
         status = tlvsw_pkg::STATUS_LEN_ERR;
      end else if (hidx_in != '0) begin
         status = tlvsw_pkg::STATUS_TRUNC;
      end else begin
         status = tlvsw_pkg::STATUS_OK;
      end

      rpt_res              = '0;
      rpt_res.kind         = tlvsw_pkg::KIND_HEADER;
      rpt_res.rtype        = hbits_full[31:16];
      rpt_res.rlen         = hbits_full[15:0];
      rpt_res.voffset      = pos_next;
      rpt_res.hit          = hit;
      rpt_res.last         = ~is_last;

      sum_res              = '0;
      sum_res.kind         = tlvsw_pkg::KIND_SUMMARY;
      sum_res.status       = status;
      sum_res.records      = rec_cnt_in;
      sum_res.match_total  = match_cnt_in;
      sum_res.found        = found_in;
      sum_res.first_offset = found_in ? first_pos_in : '0;
      sum_res.last         = 1'b1;

      // end of buffer starts a fresh walk
      if (is_last) begin
         pos_in       = '0;
         hidx_in      = '0;
         hbits_in     = '0;
         vleft_in     = '0;
         rec_cnt_in   = '0;
         match_cnt_in = '0;
         first_pos_in = '0;
         found_in     = 1'b0;
         len_err_in   = 1'b0;
      end

      push_n = in_accept
         ? (tlvsw_pkg::QCNT_W'(rpt_fire) + tlvsw_pkg::QCNT_W'(is_last)) : '0;
      wr_ptr_in = wr_ptr_ff + push_n[tlvsw_pkg::QPTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + tlvsw_pkg::QPTR_W'(out_pop);
      count_in  = count_ff + push_n - tlvsw_pkg::QCNT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hidx_ff      <= '0;
         hbits_ff     <= '0;
         vleft_ff     <= '0;
         rec_cnt_ff   <= '0;
         match_cnt_ff <= '0;
         first_pos_ff <= '0;
         found_ff     <= 1'b0;
         len_err_ff   <= 1'b0;
      end else if (in_accept) begin
         pos_ff       <= pos_in;
         hidx_ff      <= hidx_in;
         hbits_ff     <= hbits_in;
         vleft_ff     <= vleft_in;
         rec_cnt_ff   <= rec_cnt_in;
         match_cnt_ff <= match_cnt_in;
         first_pos_ff <= first_pos_in;
         found_ff     <= found_in;
         len_err_ff   <= len_err_in;
      end
   end

   // result queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result queue payload, header report ahead of summary
   always_ff @(posedge clock) begin
      if (in_accept) begin
         if (rpt_fire) begin
            queue_ff[wr_ptr_ff] <= rpt_res;
            if (is_last) begin
               queue_ff[wr_ptr_ff + tlvsw_pkg::QPTR_W'(1)] <= sum_res;
            end
         end else if (is_last) begin
            queue_ff[wr_ptr_ff] <= sum_res;
         end
      end
   end

   assign head                   = queue_ff[rd_ptr_ff];
   assign rsp_result_kind        = head.kind;
   assign rsp_record_type        = head.rtype;
   assign rsp_record_length      = head.rlen;
   assign rsp_value_offset       = head.voffset;
   assign rsp_type_matches       = head.hit;
   assign rsp_walk_status        = head.status;
   assign rsp_records_seen       = head.records;
   assign rsp_matches_seen       = head.match_total;
   assign rsp_match_found        = head.found;
   assign rsp_first_match_offset = head.first_offset;
   assign rsp_last_result        = head.last;

   `TLVSW_ASSERT_ALWAYS(a_queue_bound, count_ff <= tlvsw_pkg::QCNT_W'(tlvsw_pkg::QUEUE_DEPTH))
   `TLVSW_ASSERT_ALWAYS(a_match_le_rec, match_cnt_ff <= rec_cnt_ff)
   `TLVSW_ASSERT_IMPLY(a_no_found_no_match, !found_ff, match_cnt_ff == '0)
   `TLVSW_ASSERT_IMPLY(a_header_gather, hidx_ff != '0, (vleft_ff == '0) && !len_err_ff)

endmodule

FILE: dv/tlv_stream_walker_test.sv
`timescale 1ns / 1ps

module tlv_stream_walker_test;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_BYTES = 1300;
   localparam int unsigned MAX_IDLE = 17;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [tlvsw_pkg::BYTE_W-1:0]      req_byte_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_result_kind;
   logic [tlvsw_pkg::WORD_W-1:0]      rsp_record_type;
   logic [tlvsw_pkg::WORD_W-1:0]      rsp_record_length;
   logic [tlvsw_pkg::WORD_W-1:0]      rsp_value_offset;
   logic                              rsp_type_matches;
   logic [tlvsw_pkg::STATUS_W-1:0]    rsp_walk_status;
   logic [tlvsw_pkg::CNT_W-1:0]       rsp_records_seen;
   logic [tlvsw_pkg::CNT_W-1:0]       rsp_matches_seen;
   logic                              rsp_match_found;
   logic [tlvsw_pkg::WORD_W-1:0]      rsp_first_match_offset;
   logic                              rsp_last_result;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tlvsw_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [tlvsw_pkg::WORD_W-1:0]      csr_wdata = '0;

   // shadow registers and walk state
   logic [tlvsw_pkg::WORD_W-1:0]      buf_len = 16'd1;
   logic [tlvsw_pkg::WORD_W-1:0]      want_type = 16'd0;
   logic [tlvsw_pkg::WORD_W-1:0]      pos = '0;
   int unsigned                       hdr_count = 0;
   logic [31:0]                       hdr_word = '0;
   logic [tlvsw_pkg::WORD_W-1:0]      value_left = '0;
   logic [tlvsw_pkg::CNT_W-1:0]       rec_count = '0;
   logic [tlvsw_pkg::CNT_W-1:0]       hit_count = '0;
   logic [tlvsw_pkg::WORD_W-1:0]      first_hit_pos = '0;
   logic                              hit_seen = 1'b0;
   logic                              len_error = 1'b0;

   tlvsw_pkg::result_type             walk_results_due[$];
   logic [tlvsw_pkg::BYTE_W-1:0]      buffer_bytes[$];
   int unsigned                       mismatches = 0;
   int unsigned                       cycle_count = 0;
   int unsigned                       rsp_hold = 0;
   bit                                req_idle = 1'b1;
   bit                                rsp_idle = 1'b1;

   tlv_stream_walker u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_byte_value         (req_byte_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_record_type        (rsp_record_type),
      .rsp_record_length      (rsp_record_length),
      .rsp_value_offset       (rsp_value_offset),
      .rsp_type_matches       (rsp_type_matches),
      .rsp_walk_status        (rsp_walk_status),
      .rsp_records_seen       (rsp_records_seen),
      .rsp_matches_seen       (rsp_matches_seen),
      .rsp_match_found        (rsp_match_found),
      .rsp_first_match_offset (rsp_first_match_offset),
      .rsp_last_result        (rsp_last_result),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tlv_stream_walker_test failed");
         $finish;
      end
   end

   function automatic void walk_byte(input logic [tlvsw_pkg::BYTE_W-1:0] value);
      logic [tlvsw_pkg::WORD_W-1:0] nxt;
      logic [tlvsw_pkg::WORD_W-1:0] room;
      logic                         at_end;
      logic                         hit;
      tlvsw_pkg::result_type        beat;
      tlvsw_pkg::result_type        made[$];
      nxt = pos + 16'd1;
      at_end = (nxt == buf_len);
      if (!len_error) begin
         if (value_left != '0) begin
            value_left = value_left - 16'd1;
         end else begin
            hdr_word = {hdr_word[23:0], value};
            hdr_count++;
            if (hdr_count == 4) begin
               room = buf_len - nxt;
               hdr_count = 0;
               if (hdr_word[15:0] > room) begin
                  len_error = 1'b1;
               end else begin
                  hit = (hdr_word[31:16] == want_type);
                  value_left = hdr_word[15:0];
                  if (rec_count != tlvsw_pkg::CNT_MAX) rec_count++;
                  if (hit) begin
                     if (hit_count != tlvsw_pkg::CNT_MAX) hit_count++;
                     if (!hit_seen) begin
                        hit_seen = 1'b1;
                        first_hit_pos = nxt;
                     end
                  end
                  beat = '0;
                  beat.kind = tlvsw_pkg::KIND_HEADER;
                  beat.rtype = hdr_word[31:16];
                  beat.rlen = hdr_word[15:0];
                  beat.voffset = nxt;
                  beat.hit = hit;
                  made.push_back(beat);
               end
               hdr_word = '0;
            end
         end
      end
      if (at_end) begin
         beat = '0;
         beat.kind = tlvsw_pkg::KIND_SUMMARY;
         if (len_error || value_left != '0) beat.status = tlvsw_pkg::STATUS_LEN_ERR;
         else if (hdr_count != 0) beat.status = tlvsw_pkg::STATUS_TRUNC;
         else beat.status = tlvsw_pkg::STATUS_OK;
         beat.records = rec_count;
         beat.match_total = hit_count;
         beat.found = hit_seen;
         beat.first_offset = hit_seen ? first_hit_pos : '0;
         made.push_back(beat);
         pos = '0;
         hdr_count = 0;
         hdr_word = '0;
         value_left = '0;
         rec_count = '0;
         hit_count = '0;
         first_hit_pos = '0;
         hit_seen = 1'b0;
         len_error = 1'b0;
      end else begin
         pos = nxt;
      end
      if (made.size() != 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) walk_results_due.push_back(made[i]);
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 100) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   // config, byte and result beats are all sampled at the same edge
   always @(posedge clock) begin
      tlvsw_pkg::result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == tlvsw_pkg::REG_BUFFER_LENGTH) buf_len = csr_wdata;
            else if (csr_index == tlvsw_pkg::REG_MATCH_TYPE) want_type = csr_wdata;
         end
         if (req_valid && !req_stall) walk_byte(req_byte_value);
         if (rsp_valid && !rsp_stall) begin
            if (walk_results_due.size() == 0) begin
               mismatches++;
               $error("result beat with nothing expected");
            end else begin
               want = walk_results_due.pop_front();
               check_field("result_kind", want.kind, rsp_result_kind);
               check_field("record_type", want.rtype, rsp_record_type);
               check_field("record_length", want.rlen, rsp_record_length);
               check_field("value_offset", want.voffset, rsp_value_offset);
               check_field("type_matches", want.hit, rsp_type_matches);
               check_field("walk_status", want.status, rsp_walk_status);
               check_field("records_seen", want.records, rsp_records_seen);
               check_field("matches_seen", want.match_total, rsp_matches_seen);
               check_field("match_found", want.found, rsp_match_found);
               check_field("first_match_offset", want.first_offset, rsp_first_match_offset);
               check_field("last_result", want.last, rsp_last_result);
            end
         end
      end
   end

   // result side: random stall after each beat while rsp_idle is set, plus a long hold-off on request
   initial begin : rsp_side
      int unsigned wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) wait_left = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (wait_left != 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [tlvsw_pkg::BYTE_W-1:0] value);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_bytes();
      foreach (buffer_bytes[i]) send_byte(buffer_bytes[i]);
      req_valid <= 1'b0;
      buffer_bytes.delete();
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [tlvsw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tlvsw_pkg::WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // all results in, then idle clocks so that bytes that give none are through
   task automatic settle();
      while (walk_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void push_record(input logic [tlvsw_pkg::WORD_W-1:0] rtype,
                                       input logic [tlvsw_pkg::WORD_W-1:0] rlen);
      buffer_bytes.push_back(rtype[15:8]);
      buffer_bytes.push_back(rtype[7:0]);
      buffer_bytes.push_back(rlen[15:8]);
      buffer_bytes.push_back(rlen[7:0]);
   endfunction

   // mostly well-formed records, some with an overlong length, some pure noise
   function automatic void make_buffer(input int unsigned blen);
      int unsigned                  rem;
      int unsigned                  style;
      int unsigned                  cap;
      logic [tlvsw_pkg::WORD_W-1:0] rlen;
      logic [tlvsw_pkg::WORD_W-1:0] rtype;
      style = $urandom_range(0, 9);
      rem = (style == 9) ? 0 : blen;
      if (style == 9) begin
         repeat (blen) buffer_bytes.push_back(8'($urandom));
      end
      while (rem >= 4) begin
         rtype = ($urandom_range(0, 2) == 0) ? want_type : 16'($urandom);
         cap = (rem - 4 < 12) ? rem - 4 : 12;
         if (style >= 7 && $urandom_range(0, 3) == 0) begin
            rlen = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'(rem - 4 + $urandom_range(1, 600));
         end else if (rem - 4 <= 12 && $urandom_range(0, 1) == 0) begin
            rlen = 16'(rem - 4);
         end else begin
            rlen = 16'($urandom_range(0, cap));
         end
         push_record(rtype, rlen);
         rem -= 4;
         if (rlen > rem) break;
         repeat (rlen) buffer_bytes.push_back(8'($urandom));
         rem -= rlen;
      end
      repeat (rem) buffer_bytes.push_back(8'($urandom));
   endfunction

   // buffer_length left at its reset value: every byte ends a buffer
   task automatic test_single_byte_buffers();
      buffer_bytes.push_back(8'h00);
      send_bytes();
      buffer_bytes.push_back(8'hFF);
      send_bytes();
   endtask

   // second header lands on the last byte: report then summary
   task automatic test_header_extremes();
      settle();
      write_reg(tlvsw_pkg::REG_BUFFER_LENGTH, 16'd8);
      write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'hFFFF);
      push_record(16'hFFFF, 16'h0000);
      push_record(16'h0000, 16'h0000);
      send_bytes();
   endtask

   task automatic test_length_too_long();
      settle();
      write_reg(tlvsw_pkg::REG_BUFFER_LENGTH, 16'd10);
      write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'h1234);
      push_record(16'h1234, 16'd1);
      buffer_bytes.push_back(8'hA5);
      push_record(16'h0000, 16'hFFFF);
      buffer_bytes.push_back(8'h5A);
      send_bytes();
   endtask

   task automatic test_midwalk_changes();
      settle();
      write_reg(tlvsw_pkg::REG_BUFFER_LENGTH, 16'd20);
      write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'd5);
      push_record(16'h00AB, 16'd10);
      buffer_bytes.push_back(8'h11);
      buffer_bytes.push_back(8'h22);
      send_bytes();
      // shrink the buffer while value bytes are still owed
      settle();
      write_reg(tlvsw_pkg::REG_BUFFER_LENGTH, 16'd8);
      buffer_bytes.push_back(8'h33);
      buffer_bytes.push_back(8'h44);
      send_bytes();
      settle();
      push_record(16'd5, 16'd0);
      send_bytes();
      settle();
      write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'd7);
      push_record(16'd7, 16'd0);
      send_bytes();
   endtask

   task automatic test_backpressure();
      settle();
      req_idle = 1'b0;
      rsp_idle = 1'b1;
      write_reg(tlvsw_pkg::REG_BUFFER_LENGTH, 16'd96);
      write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'h00C3);
      repeat (12) push_record(($urandom_range(0, 1) == 0) ? 16'h00C3 : 16'($urandom), 16'd0);
      rsp_hold = 150;
      send_bytes();
      // pause mid-buffer until the result side has caught up
      while (walk_results_due.size() != 0) @(posedge clock);
      repeat (12) push_record(($urandom_range(0, 1) == 0) ? 16'h00C3 : 16'($urandom), 16'd0);
      send_bytes();
      req_idle = 1'b1;
   endtask

   task automatic test_random_buffers();
      int unsigned sent;
      int unsigned blen;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         blen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 64);
         settle();
         req_idle = ($urandom_range(0, 4) != 0);
         rsp_idle = ($urandom_range(0, 4) != 0);
         write_reg(tlvsw_pkg::REG_BUFFER_LENGTH, 16'(blen));
         case ($urandom_range(0, 5))
            0: write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'h0000);
            1: write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'hFFFF);
            2: write_reg(tlvsw_pkg::REG_MATCH_TYPE, 16'($urandom));
            default: ;
         endcase
         make_buffer(blen);
         send_bytes();
         sent += blen;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_byte_buffers();
      test_header_extremes();
      test_length_too_long();
      test_midwalk_changes();
      test_backpressure();
      test_random_buffers();
      while (walk_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tlv_stream_walker_test passed");
      end else begin
         $display("tlv_stream_walker_test failed");
      end
      $finish;
   end

endmodule
